/* rtl/ksrt_pkg.sv */
package ksrt_pkg;

  // Default configuration of the sorter
  localparam int unsigned DefCapacity    = 64;
  localparam int unsigned DefKeyBits     = 64;
  localparam int unsigned DefPayloadBits = 64;

endpackage

/* rtl/ksrt_ram.sv */
module ksrt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one registered read port; read data holds without re_i
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/key_payload_sorter_unit.sv */
// Stable key/payload sorter.
// Input channel (in_valid_i/in_ready_o) takes one record per transaction:
// key_i, payload_i and last_item_i. Records are kept sorted in one RAM by
// insertion: each new record walks down from the top of the stored set,
// moving larger keys up one entry per cycle, so equal keys keep input order.
// A record makes m moves, m being the number of stored keys greater than
// its own (up to CAPACITY - 1); the RAM read/write loop sets this pace.
// A record that arrives with the store full is dropped and the overflow
// flag is set for the set.
// When a record with last_item_i arrives, the set is drained in ascending
// order on the output channel (out_valid_o/out_ready_i), each record read
// (S_DRD) and then presented (S_DOUT); last_out_o marks the final record and
// overflowed_o is high on every record of a set that lost records.
// A stalled receiver simply holds the current result; no input is taken
// during the drain. Reset empties the set; the RAM needs no clearing.
module key_payload_sorter_unit #(
  parameter int unsigned CAPACITY     = ksrt_pkg::DefCapacity,
  parameter int unsigned KEY_BITS     = ksrt_pkg::DefKeyBits,
  parameter int unsigned PAYLOAD_BITS = ksrt_pkg::DefPayloadBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [KEY_BITS-1:0]     key_i,
  input  logic [PAYLOAD_BITS-1:0] payload_i,
  input  logic                    last_item_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [KEY_BITS-1:0]     sorted_key_o,
  output logic [PAYLOAD_BITS-1:0] sorted_payload_o,
  output logic                    last_out_o,
  output logic                    overflowed_o
);

  import ksrt_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned DW = KEY_BITS + PAYLOAD_BITS;
  localparam logic [CW-1:0] Cap = CW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE, S_INS, S_CMP, S_DRD, S_DOUT
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     fill_q, fill_d;
  logic [CW-1:0]     pos_q, pos_d;
  logic              ovf_q, ovf_d;
  logic              last_q, last_d;
  logic [KEY_BITS-1:0]     key_q, key_d;
  logic [PAYLOAD_BITS-1:0] pay_q, pay_d;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;
  logic [CW-1:0] pos_m1, pos_m2;

  assign pos_m1 = pos_q - CW'(1);
  assign pos_m2 = pos_q - CW'(2);

  ksrt_ram #(
    .Width(DW),
    .Depth(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Insertion and drain sequencing
  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    pos_d   = pos_q;
    ovf_d   = ovf_q;
    last_d  = last_q;
    key_d   = key_q;
    pay_d   = pay_q;
    we      = 1'b0;
    re      = 1'b0;
    waddr   = pos_q[AW-1:0];
    wdata   = {key_q, pay_q};
    raddr   = pos_m1[AW-1:0];
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          key_d  = key_i;
          pay_d  = payload_i;
          last_d = last_item_i;
          pos_d  = fill_q;
          if (fill_q == Cap) begin
            ovf_d = 1'b1;
            if (last_item_i) begin
              pos_d   = '0;
              state_d = S_DRD;
            end
          end else begin
            state_d = S_INS;
          end
        end
      end
      S_INS: begin
        if (pos_q == '0) begin
          // new record goes to the bottom
          we     = 1'b1;
          fill_d = fill_q + CW'(1);
          pos_d  = '0;
          state_d = last_q ? S_DRD : S_IDLE;
        end else begin
          re      = 1'b1;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (rdata[DW-1:PAYLOAD_BITS] > key_q) begin
          // move larger record up one entry
          we    = 1'b1;
          wdata = rdata;
          pos_d = pos_m1;
          if (pos_m1 == '0) begin
            state_d = S_INS;
          end else begin
            re    = 1'b1;
            raddr = pos_m2[AW-1:0];
          end
        end else begin
          we     = 1'b1;
          fill_d = fill_q + CW'(1);
          pos_d  = '0;
          state_d = last_q ? S_DRD : S_IDLE;
        end
      end
      S_DRD: begin
        re      = 1'b1;
        raddr   = pos_q[AW-1:0];
        state_d = S_DOUT;
      end
      S_DOUT: begin
        if (out_ready_i) begin
          if (pos_q == fill_q - CW'(1)) begin
            fill_d  = '0;
            ovf_d   = 1'b0;
            state_d = S_IDLE;
          end else begin
            pos_d   = pos_q + CW'(1);
            state_d = S_DRD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      pos_q   <= '0;
      ovf_q   <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      pos_q   <= pos_d;
      ovf_q   <= ovf_d;
      last_q  <= last_d;
    end
  end

  // Record being inserted
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pay_q <= pay_d;
  end

  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = (state_q == S_DOUT);
  assign sorted_key_o     = rdata[DW-1:PAYLOAD_BITS];
  assign sorted_payload_o = rdata[PAYLOAD_BITS-1:0];
  assign last_out_o       = (pos_q == fill_q - CW'(1));
  assign overflowed_o     = ovf_q;

endmodule
